// ===== rtl/bc_pkg.sv =====
// package: constants, coefficient and sideband types, calibration decode
package bc_pkg;

    localparam int TEMP_FRAC_BITS  = 16;
    localparam int PRESS_FRAC_BITS = 6;
    localparam int DEN_BITS        = 181;
    localparam int TEMP_SHIFT      = 48 - TEMP_FRAC_BITS;
    localparam int PRESS_SHIFT     = DEN_BITS - PRESS_FRAC_BITS;

    localparam int LIMB_W = 32;
    localparam int N_W    = 2 * LIMB_W;
    localparam int X_W    = 5 * LIMB_W;
    localparam int ACC_W  = 7 * LIMB_W;
    localparam int CAL_W  = 168;

    localparam int TEMP_W  = 24;
    localparam int PRESS_W = 23;

    localparam longint T_LO_RAW = -(longint'(40) <<< TEMP_FRAC_BITS);
    localparam longint T_HI_RAW = longint'(85) <<< TEMP_FRAC_BITS;
    localparam longint T_LO     = (T_LO_RAW < -longint'(8388608)) ? -longint'(8388608) : T_LO_RAW;
    localparam longint T_HI     = (T_HI_RAW > longint'(8388607)) ? longint'(8388607) : T_HI_RAW;

    localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

    typedef enum logic [1:0] {
        REG_CAL_LO  = 2'd0,
        REG_CAL_MID = 2'd1,
        REG_CAL_HI  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } coeff_t;

    typedef struct packed {
        logic signed [N_W-1:0]    n;
        logic signed [TEMP_W-1:0] tq;
        logic                     tsat;
        logic signed [ACC_W-1:0]  a1;
        logic signed [ACC_W-1:0]  a0p;
        logic signed [80:0]       p11;
    } side_t;

    function automatic coeff_t decode_calib(input logic [CAL_W-1:0] cal);
        coeff_t c;
        c.t1  = cal[0*8 +: 16];
        c.t2  = cal[2*8 +: 16];
        c.t3  = cal[4*8 +: 8];
        c.p1  = cal[5*8 +: 16];
        c.p2  = cal[7*8 +: 16];
        c.p3  = cal[9*8 +: 8];
        c.p4  = cal[10*8 +: 8];
        c.p5  = cal[11*8 +: 16];
        c.p6  = cal[13*8 +: 16];
        c.p7  = cal[15*8 +: 8];
        c.p8  = cal[16*8 +: 8];
        c.p9  = cal[17*8 +: 16];
        c.p10 = cal[19*8 +: 8];
        c.p11 = cal[20*8 +: 8];
        return c;
    endfunction

endpackage

// ===== rtl/barometer_compensation_top.sv =====
// top level: calibration registers, front end, three horner steps, output stage
//
// One raw pressure and temperature pair goes in, one compensated result comes
// out, in order. The pipeline takes a new item every cycle while it is not
// full and stalled; it has 4 front-end stages, three horner steps of 3 stages
// each on 33 x 33 bit limb multipliers, and the output register.
// Stalls on the result side hold the pipeline without loss, and empty stages
// close up, so items are still taken while a result waits. The calibration
// port is always ready and must be written only while no item is in flight.
module barometer_compensation_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [63:0]                         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [23:0]                         s_raw_pressure,
    input  logic [23:0]                         s_raw_temperature,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bc_pkg::TEMP_W-1:0]    m_temperature_fixed,
    output logic [bc_pkg::PRESS_W-1:0]          m_pressure_fixed,
    output logic                                m_saturated
);
    import bc_pkg::*;

    logic [63:0] cal_lo_reg, cal_mid_reg;
    logic [39:0] cal_hi_reg;
    coeff_t      coeff;

    logic                    f_valid, f_ready;
    logic signed [X_W-1:0]   f_a3;
    logic signed [ACC_W-1:0] f_a2;
    side_t                   f_side;

    logic                    h1_valid, h1_ready, h2_valid, h2_ready, h3_valid, h3_ready;
    logic signed [ACC_W-1:0] h1_y, h2_y, h3_y, h3_add;
    side_t                   h1_side, h2_side, h3_side;

    logic                    ov_reg, en_o;
    logic signed [ACC_W-1:0] q;
    logic [PRESS_W-1:0]      pq_next, pq_reg;
    logic                    sat_next, sat_reg;
    logic signed [TEMP_W-1:0] tq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_lo_reg  <= '0;
            cal_mid_reg <= '0;
            cal_hi_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CAL_LO:  cal_lo_reg  <= cfg_data;
                REG_CAL_MID: cal_mid_reg <= cfg_data;
                REG_CAL_HI:  cal_hi_reg  <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    assign coeff = decode_calib({cal_hi_reg, cal_mid_reg, cal_lo_reg});

    bc_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .coeff              (coeff),
        .in_valid           (s_valid),
        .in_ready           (s_ready),
        .in_raw_pressure    (s_raw_pressure),
        .in_raw_temperature (s_raw_temperature),
        .out_valid          (f_valid),
        .out_ready          (f_ready),
        .out_a3             (f_a3),
        .out_a2             (f_a2),
        .out_side           (f_side)
    );

    bc_horner_step u_step1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_x      (f_a3),
        .in_add    (f_a2),
        .in_side   (f_side),
        .out_valid (h1_valid),
        .out_ready (h1_ready),
        .out_y     (h1_y),
        .out_side  (h1_side)
    );

    bc_horner_step u_step2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h1_valid),
        .in_ready  (h1_ready),
        .in_x      (h1_y[X_W-1:0]),
        .in_add    (h1_side.a1),
        .in_side   (h1_side),
        .out_valid (h2_valid),
        .out_ready (h2_ready),
        .out_y     (h2_y),
        .out_side  (h2_side)
    );

    assign h3_add = h2_side.a0p + (ACC_W'(h2_side.p11) <<< 116);

    bc_horner_step u_step3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h2_valid),
        .in_ready  (h2_ready),
        .in_x      (h2_y[X_W-1:0]),
        .in_add    (h3_add),
        .in_side   (h2_side),
        .out_valid (h3_valid),
        .out_ready (h3_ready),
        .out_y     (h3_y),
        .out_side  (h3_side)
    );

    // output stage: scale, clamp
    assign en_o     = !ov_reg || m_ready;
    assign h3_ready = en_o;
    assign q        = h3_y >>> PRESS_SHIFT;

    always_comb begin
        pq_next  = q[PRESS_W-1:0];
        sat_next = h3_side.tsat;
        if (q[ACC_W-1]) begin
            pq_next  = '0;
            sat_next = 1'b1;
        end else if (|q[ACC_W-1:PRESS_W]) begin
            pq_next  = PRESS_MAX;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en_o) begin
            ov_reg <= h3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_o) begin
            pq_reg  <= pq_next;
            sat_reg <= sat_next;
            tq_reg  <= h3_side.tq;
        end
    end

    assign m_valid             = ov_reg;
    assign m_temperature_fixed = tq_reg;
    assign m_pressure_fixed    = pq_reg;
    assign m_saturated         = sat_reg;

endmodule

// ===== rtl/bc_front.sv =====
// front end: raw powers, linearised temperature and polynomial coefficients
module bc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bc_pkg::coeff_t              coeff,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [23:0]                 in_raw_pressure,
    input  logic [23:0]                 in_raw_temperature,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [bc_pkg::X_W-1:0]   out_a3,
    output logic signed [bc_pkg::ACC_W-1:0] out_a2,
    output bc_pkg::side_t               out_side
);
    import bc_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [25:0] d_next, d_reg;
    logic        [23:0] p1s_reg, p2s_reg;
    logic        [47:0] sq_next, sq_reg, sq2_reg;

    logic signed [42:0] dt2_next, dt2_reg;
    logic signed [51:0] dd_next, dd_reg;
    logic        [47:0] p3a_next, p3a_reg, p3b_next, p3b_reg;
    logic signed [16:0] p1m, p2m;
    logic signed [41:0] pp1_next, pp1_reg, pp1b_reg, pp2_next, pp2_reg, pp2b_reg;
    logic signed [32:0] pp3_next, pp3_reg, pp3b_reg, pp4_next, pp4_reg, pp4b_reg;

    logic signed [59:0]    ddt3;
    logic signed [N_W-1:0] n_next, n_reg;
    logic        [71:0]    cube_next, cube_reg;
    logic signed [64:0]    p9_next, p9_reg;
    logic signed [56:0]    p10_next, p10_reg;

    logic signed [N_W-1:0]   tsum, tfull;
    logic signed [TEMP_W-1:0] tq;
    logic                    tsat;
    logic signed [80:0]      p11;
    logic signed [X_W-1:0]   a3_next, a3_reg;
    logic signed [ACC_W-1:0] a2_next, a2_reg;
    side_t                   side_next, side_reg;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1
    assign d_next  = $signed({2'b00, in_raw_temperature}) - $signed({2'b00, coeff.t1, 8'h00});
    assign sq_next = {24'd0, in_raw_pressure} * {24'd0, in_raw_pressure};

    always_ff @(posedge aclk) begin
        if (en1) begin
            d_reg   <= d_next;
            p1s_reg <= in_raw_pressure;
            sq_reg  <= sq_next;
        end
    end

    // stage 2
    assign p1m      = $signed({coeff.p1[15], coeff.p1}) - 17'sd16384;
    assign p2m      = $signed({coeff.p2[15], coeff.p2}) - 17'sd16384;
    assign dt2_next = d_reg * $signed({1'b0, coeff.t2});
    assign dd_next  = d_reg * d_reg;
    assign p3a_next = {24'd0, sq_reg[23:0]} * {24'd0, p1s_reg};
    assign p3b_next = {24'd0, sq_reg[47:24]} * {24'd0, p1s_reg};
    assign pp1_next = p1m * $signed({1'b0, p1s_reg});
    assign pp2_next = p2m * $signed({1'b0, p1s_reg});
    assign pp3_next = coeff.p3 * $signed({1'b0, p1s_reg});
    assign pp4_next = coeff.p4 * $signed({1'b0, p1s_reg});

    always_ff @(posedge aclk) begin
        if (en2) begin
            dt2_reg <= dt2_next;
            dd_reg  <= dd_next;
            p3a_reg <= p3a_next;
            p3b_reg <= p3b_next;
            pp1_reg <= pp1_next;
            pp2_reg <= pp2_next;
            pp3_reg <= pp3_next;
            pp4_reg <= pp4_next;
            sq2_reg <= sq_reg;
        end
    end

    // stage 3
    assign ddt3      = dd_reg * coeff.t3;
    assign n_next    = (N_W'(dt2_reg) <<< 18) + N_W'(ddt3);
    assign cube_next = {24'd0, p3a_reg} + ({24'd0, p3b_reg} << 24);
    assign p9_next   = coeff.p9 * $signed({1'b0, sq2_reg});
    assign p10_next  = coeff.p10 * $signed({1'b0, sq2_reg});

    always_ff @(posedge aclk) begin
        if (en3) begin
            n_reg    <= n_next;
            cube_reg <= cube_next;
            p9_reg   <= p9_next;
            p10_reg  <= p10_next;
            pp1b_reg <= pp1_reg;
            pp2b_reg <= pp2_reg;
            pp3b_reg <= pp3_reg;
            pp4b_reg <= pp4_reg;
        end
    end

    // stage 4
    always_comb begin
        tsum  = n_reg + (N_W'(1) <<< (TEMP_SHIFT - 1));
        tfull = tsum >>> TEMP_SHIFT;
        tsat  = 1'b0;
        tq    = TEMP_W'(tfull);
        if (tfull < N_W'(T_LO)) begin
            tq   = TEMP_W'(T_LO);
            tsat = 1'b1;
        end else if (tfull > N_W'(T_HI)) begin
            tq   = TEMP_W'(T_HI);
            tsat = 1'b1;
        end
    end

    assign p11     = coeff.p11 * $signed({1'b0, cube_reg});
    assign a3_next = (X_W'(coeff.p8) <<< 22) + X_W'(pp4b_reg);
    assign a2_next = (ACC_W'(coeff.p7) <<< 77) + (ACC_W'(pp3b_reg) <<< 53);

    always_comb begin
        side_next.n    = n_reg;
        side_next.tq   = tq;
        side_next.tsat = tsat;
        side_next.p11  = p11;
        side_next.a1   = (ACC_W'($signed({1'b0, coeff.p6})) <<< 127)
                       + (ACC_W'(pp2b_reg) <<< 104)
                       + (ACC_W'(p10_reg) <<< 85);
        side_next.a0p  = (ACC_W'($signed({1'b0, coeff.p5})) <<< 184)
                       + (ACC_W'(pp1b_reg) <<< 161)
                       + (ACC_W'(p9_reg) <<< 133)
                       + (ACC_W'(1) <<< (PRESS_SHIFT - 1));
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            a3_reg   <= a3_next;
            a2_reg   <= a2_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_a3    = a3_reg;
    assign out_a2    = a2_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/bc_horner_step.sv =====
// one horner step y = addend + n * x over limb partial products, three stages
module bc_horner_step (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [bc_pkg::X_W-1:0]   in_x,
    input  logic signed [bc_pkg::ACC_W-1:0] in_add,
    input  bc_pkg::side_t                   in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [bc_pkg::ACC_W-1:0] out_y,
    output bc_pkg::side_t                   out_side
);
    import bc_pkg::*;

    localparam int NL = N_W / LIMB_W;
    localparam int XL = X_W / LIMB_W;

    logic va_reg, vb_reg, vc_reg;
    logic ena, enb, enc;

    logic signed [2*LIMB_W+1:0] pp_next [NL][XL];
    logic signed [2*LIMB_W+1:0] pp_reg  [NL][XL];
    logic signed [ACC_W-1:0]    row_next [NL];
    logic signed [ACC_W-1:0]    row_reg  [NL];
    logic signed [ACC_W-1:0]    adda_reg, addb_reg;
    logic signed [ACC_W-1:0]    y_next, y_reg;
    side_t                      sidea_reg, sideb_reg, sidec_reg;

    assign enc      = !vc_reg || out_ready;
    assign enb      = !vb_reg || enc;
    assign ena      = !va_reg || enb;
    assign in_ready = ena;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (ena) va_reg <= in_valid;
            if (enb) vb_reg <= va_reg;
            if (enc) vc_reg <= vb_reg;
        end
    end

    // partial products, top limbs signed
    always_comb begin
        logic [LIMB_W:0] a;
        logic [LIMB_W:0] b;
        for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < XL; j++) begin
                if (i == NL - 1) a = {in_side.n[LIMB_W*i+LIMB_W-1], in_side.n[LIMB_W*i +: LIMB_W]};
                else             a = {1'b0, in_side.n[LIMB_W*i +: LIMB_W]};
                if (j == XL - 1) b = {in_x[LIMB_W*j+LIMB_W-1], in_x[LIMB_W*j +: LIMB_W]};
                else             b = {1'b0, in_x[LIMB_W*j +: LIMB_W]};
                pp_next[i][j] = $signed(a) * $signed(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ena) begin
            pp_reg    <= pp_next;
            adda_reg  <= in_add;
            sidea_reg <= in_side;
        end
    end

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < XL; j++) begin
                row_next[i] = row_next[i] + (ACC_W'(pp_reg[i][j]) <<< (LIMB_W * j));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (enb) begin
            row_reg   <= row_next;
            addb_reg  <= adda_reg;
            sideb_reg <= sidea_reg;
        end
    end

    always_comb begin
        y_next = addb_reg;
        for (int i = 0; i < NL; i++) begin
            y_next = y_next + (row_reg[i] <<< (LIMB_W * i));
        end
    end

    always_ff @(posedge aclk) begin
        if (enc) begin
            y_reg     <= y_next;
            sidec_reg <= sideb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_y     = y_reg;
    assign out_side  = sidec_reg;

endmodule
